FILE: hdl/tbpr_pkg.sv
// Shared types, constants and helper functions for the tile background pixel renderer.
// No dependencies; imported by every module of the block.
package tbpr_pkg;

  localparam int VRAM_BYTES   = 8192;
  localparam int SCREEN_WIDTH = 160;
  localparam int VRAM_AW      = $clog2(VRAM_BYTES);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_LCD_CONTROL = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SCROLL_Y    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SCROLL_X    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_Y    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_X    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_BG_PALETTE  = 3'd5;

  // lcd_control bit positions
  localparam int LCDC_DRAW_EN  = 0;
  localparam int LCDC_BG_MAP   = 3;
  localparam int LCDC_TILE_SEL = 4;
  localparam int LCDC_WIN_EN   = 5;
  localparam int LCDC_WIN_MAP  = 6;

  // offsets from the start of video memory
  localparam logic [VRAM_AW-1:0] MAP0_OFS        = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP1_OFS        = 13'h1C00;
  localparam logic [VRAM_AW-1:0] SIGNED_TILE_OFS = 13'h0800;

  localparam logic [7:0] WIN_X_BIAS = 8'd7;

  typedef struct packed {
    logic               opcode;
    logic [VRAM_AW-1:0] vram_addr;
    logic [7:0]         vram_data;
    logic [7:0]         pixel_x;
    logic [7:0]         scanline;
  } in_item_t;

  typedef struct packed {
    logic       drawn;
    logic [1:0] color_index;
    logic [1:0] shade;
    logic [7:0] gray;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_y;
    logic [7:0] scroll_x;
    logic [7:0] window_y;
    logic [7:0] window_x;
    logic [7:0] bg_palette;
  } cfg_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         wdata;
  } mem_req_t;

  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] color);
    logic [1:0] s;
    case (color)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      default: s = pal[7:6];
    endcase
    return s;
  endfunction

  function automatic logic [7:0] gray_of(input logic [1:0] shade);
    logic [7:0] g;
    case (shade)
      2'd0:    g = 8'hFF;
      2'd1:    g = 8'hCC;
      2'd2:    g = 8'h77;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

FILE: hdl/tile_background_pixel_render_top.sv
// Top level of the tile background pixel renderer: configuration registers,
// fetch sequencer and video memory. Depends on tbpr_pkg, tbpr_fetch, tbpr_vram.
//
// Input channel (in_valid/in_stall/in_data): a write item stores one byte in
// the 8 KB video memory; a render item returns one pixel on the output
// channel (out_valid/out_stall/out_data). Writes produce no result.
// A write is stored as it is transferred. A render with drawing enabled makes
// three dependent reads (map entry, low plane, high plane) through the single
// memory port and its registered read data, then loads the result into the
// output register; input stays stalled until then. With drawing disabled a
// render skips the reads and goes straight to the output register step.
// The output register holds a finished pixel while the receiver stalls; the
// next item is still taken, but its result waits in the last step until the
// register is free.
// After reset the memory is cleared one byte a cycle, each byte once, during
// which in_stall is high. Configuration writes (cfg_we/cfg_index/cfg_wdata)
// take effect at once and are accepted at any time, the clear included.
module tile_background_pixel_render_top
  import tbpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_wdata
);

  cfg_t       cfg_r;
  mem_req_t   mem_req;
  logic       clr_busy;
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LCD_CONTROL: cfg_r.lcd_control <= cfg_wdata;
        CFG_SCROLL_Y:    cfg_r.scroll_y    <= cfg_wdata;
        CFG_SCROLL_X:    cfg_r.scroll_x    <= cfg_wdata;
        CFG_WINDOW_Y:    cfg_r.window_y    <= cfg_wdata;
        CFG_WINDOW_X:    cfg_r.window_x    <= cfg_wdata;
        CFG_BG_PALETTE:  cfg_r.bg_palette  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbpr_fetch u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clr_busy (clr_busy),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  tbpr_vram u_vram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .clr_busy(clr_busy),
    .rd_data (rd_data)
  );

endmodule

FILE: hdl/tbpr_vram.sv
// Single-port 8 KB video memory with registered read data and a clearing pass after reset.
// Depends on tbpr_pkg.
module tbpr_vram
  import tbpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output logic     clr_busy,
  output logic [7:0] rd_data
);

  logic [7:0]         mem [VRAM_BYTES];
  logic [VRAM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               clr_busy_r, clr_busy_nxt;
  logic [7:0]         rd_data_r;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clr_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // one port: clear sweep, byte write or read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 8'h00;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end else if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign clr_busy = clr_busy_r;
  assign rd_data  = rd_data_r;

endmodule

FILE: hdl/tbpr_fetch.sv
// Pixel fetch sequencer: one shared address adder drives the map, low and high plane reads.
// Depends on tbpr_pkg; talks to tbpr_vram through a mem_req_t request.
module tbpr_fetch
  import tbpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       clr_busy,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  output mem_req_t   mem_req,
  input  logic [7:0] rd_data
);

  typedef enum logic [2:0] {S_IDLE, S_MAP, S_LO, S_HI, S_FIN} state_t;

  state_t     state_r, state_nxt;
  logic [7:0] px_r, line_r, tile_num_r, b1_r;
  logic       draw_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic               in_xfer, out_free;
  logic               use_win;
  logic [7:0]         wx, xpos, ypos, tile_sel;
  logic [VRAM_AW-1:0] map_base, tile_base, add_a, add_b, add_sum;
  logic [2:0]         bit_sel;
  logic [1:0]         color;

  assign in_stall = (state_r != S_IDLE) || clr_busy;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // pixel position within the selected map
  always_comb begin
    use_win = cfg.lcd_control[LCDC_WIN_EN] && (cfg.window_y <= line_r);
    wx      = cfg.window_x - WIN_X_BIAS;
    if (use_win) begin
      map_base = cfg.lcd_control[LCDC_WIN_MAP] ? MAP1_OFS : MAP0_OFS;
      ypos     = line_r - cfg.window_y;
    end else begin
      map_base = cfg.lcd_control[LCDC_BG_MAP] ? MAP1_OFS : MAP0_OFS;
      ypos     = cfg.scroll_y + line_r;
    end
    if (use_win && px_r >= wx) xpos = px_r - wx;
    else                       xpos = px_r + cfg.scroll_x;
  end

  // tile number arrives from memory in S_LO, held afterwards
  always_comb begin
    tile_sel = (state_r == S_LO) ? rd_data : tile_num_r;
    if (cfg.lcd_control[LCDC_TILE_SEL]) tile_base = {1'b0, tile_sel, 4'b0000};
    else tile_base = SIGNED_TILE_OFS + {1'b0, tile_sel ^ 8'h80, 4'b0000};
  end

  // shared address adder
  always_comb begin
    if (state_r == S_MAP) begin
      add_a = map_base;
      add_b = {3'b000, ypos[7:3], xpos[7:3]};
    end else begin
      add_a = tile_base;
      add_b = {9'd0, ypos[2:0], state_r == S_HI};
    end
    add_sum = add_a + add_b;
  end

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = in_data.vram_data;
    if (in_xfer && in_data.opcode == OP_WRITE) begin
      mem_req.wr_en = 1'b1;
      mem_req.addr  = in_data.vram_addr;
    end else if (state_r == S_MAP || state_r == S_LO || state_r == S_HI) begin
      mem_req.rd_en = 1'b1;
      mem_req.addr  = add_sum;
    end
  end

  // in S_FIN the read register holds the high plane byte
  always_comb begin
    bit_sel = ~xpos[2:0];
    color   = {rd_data[bit_sel], b1_r[bit_sel]};
    out_data_nxt = '0;
    if (draw_r) begin
      out_data_nxt.drawn       = 1'b1;
      out_data_nxt.color_index = color;
      out_data_nxt.shade       = shade_of(cfg.bg_palette, color);
      out_data_nxt.gray        = gray_of(out_data_nxt.shade);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_data.opcode == OP_RENDER) begin
          state_nxt = cfg.lcd_control[LCDC_DRAW_EN] ? S_MAP : S_FIN;
        end
      end
      S_MAP: state_nxt = S_LO;
      S_LO:  state_nxt = S_HI;
      S_HI:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        px_r   <= in_data.pixel_x;
        line_r <= in_data.scanline;
        draw_r <= cfg.lcd_control[LCDC_DRAW_EN];
      end
      if (state_r == S_LO) tile_num_r <= rd_data;
      if (state_r == S_HI) b1_r <= rd_data;
      if (state_r == S_FIN && out_free) out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/tbpr_checker.sv
// Port-level checks for the tile background pixel renderer, bound to the top level.
// Depends on tbpr_pkg and tile_background_pixel_render_top.
module tbpr_checker
  import tbpr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // the clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_RENDER |=> in_stall)
    else $error("render transfer not followed by busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drawn |->
      out_data.color_index == 2'd0 && out_data.shade == 2'd0 && out_data.gray == 8'h00)
    else $error("undrawn pixel not zero");

  a_gray_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drawn |->
      (out_data.shade == 2'd0 && out_data.gray == 8'hFF) ||
      (out_data.shade == 2'd1 && out_data.gray == 8'hCC) ||
      (out_data.shade == 2'd2 && out_data.gray == 8'h77) ||
      (out_data.shade == 2'd3 && out_data.gray == 8'h00))
    else $error("gray level does not match shade");

endmodule

bind tile_background_pixel_render_top tbpr_checker u_tbpr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
